// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ETD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ETD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/etd_pkg.sv
// Shared types, constants and constant functions of the Euler angle to DCM block.
package etd_pkg;

   typedef enum logic [3:0] {
      ORD_ZYX = 4'd0,
      ORD_XYZ = 4'd1,
      ORD_XYX = 4'd2,
      ORD_XZY = 4'd3,
      ORD_XZX = 4'd4,
      ORD_YXZ = 4'd5,
      ORD_YXY = 4'd6,
      ORD_YZX = 4'd7,
      ORD_YZY = 4'd8,
      ORD_ZYZ = 4'd9,
      ORD_ZXY = 4'd10,
      ORD_ZXZ = 4'd11
   } order_type;

   localparam logic signed [63:0] PI_Q60         = 64'sh3243F6A8885A308D;
   localparam logic signed [63:0] TWO_PI_Q60     = 64'sh6487ED5110B4611A;
   localparam logic signed [63:0] HALF_PI_Q60    = 64'sh1921FB54442D1847;
   localparam logic signed [63:0] QUARTER_PI_Q62 = 64'sh3243F6A8885A308D;
   localparam logic signed [63:0] GAIN_Q62       = 64'sd2800459870029452954;
   localparam logic signed [31:0] ONE_Q30        = 32'sh40000000;

   function automatic logic signed [63:0] rnd64(input logic signed [63:0] v, input int s);
      logic signed [63:0] r;
      if (s == 0) begin
         r = v;
      end else begin
         r = (v + (64'sd1 <<< (s - 1))) >>> s;
      end
      return r;
   endfunction

   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], n[b]};
         if (rem >= d) begin
            rem  = rem - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic signed [63:0] atan_q62(input int i);
      logic signed [63:0] sum;
      logic [63:0] term;
      int s;
      sum = '0;
      if (i == 0) begin
         sum = QUARTER_PI_Q62;
      end else begin
         for (int k = 0; k < 32; k++) begin
            s = i * (2 * k + 1);
            if (s <= 62) begin
               term = udiv(64'd1 << (62 - s), 64'(2 * k + 1));
               if (k % 2 == 1) begin
                  sum = sum - $signed(term);
               end else begin
                  sum = sum + $signed(term);
               end
            end
         end
      end
      return sum;
   endfunction

endpackage

// File: hdl/etd_sincos.sv
// One sine and cosine lane: range reduction, pipelined CORDIC and Q2.30 conversion.
module etd_sincos #(
   parameter int DATA_WIDTH    = 32,
   parameter int CORDIC_STAGES = 30
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] angle,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);

   localparam int FRAC = DATA_WIDTH - 2;
   localparam int ZSH  = 60 - FRAC;
   localparam int SH_R = (FRAC >= 30) ? FRAC - 30 : 0;
   localparam int SH_L = (FRAC < 30) ? 30 - FRAC : 0;
   localparam logic signed [63:0] ZHALF = 64'sd1 <<< (ZSH - 1);
   localparam logic signed [63:0] QHALF = (64'sd1 <<< SH_R) >>> 1;
   localparam logic signed [DATA_WIDTH-1:0] X_INIT =
      (DATA_WIDTH)'(etd_pkg::rnd64(etd_pkg::GAIN_Q62, 62 - FRAC));

   logic signed [66:0] a_in;
   logic signed [66:0] a_wrap_in;
   logic signed [63:0] a_ff;
   logic signed [63:0] f_in;
   logic               flip_in;
   logic signed [63:0] zr_in;

   logic signed [DATA_WIDTH-1:0] x_ff [0:CORDIC_STAGES];
   logic signed [DATA_WIDTH-1:0] y_ff [0:CORDIC_STAGES];
   logic signed [DATA_WIDTH-1:0] z_ff [0:CORDIC_STAGES];
   logic                         flip_ff [0:CORDIC_STAGES];

   logic signed [63:0] cx;
   logic signed [63:0] cy;
   logic signed [63:0] cq_in;
   logic signed [63:0] sq_in;
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_ff;

   always_comb begin
      a_in = $signed({{3{angle[31]}}, angle, 32'd0});
      if (a_in > 67'(etd_pkg::PI_Q60)) begin
         a_wrap_in = a_in - 67'(etd_pkg::TWO_PI_Q60);
      end else if (a_in < -67'(etd_pkg::PI_Q60)) begin
         a_wrap_in = a_in + 67'(etd_pkg::TWO_PI_Q60);
      end else begin
         a_wrap_in = a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_wrap_in[63:0];
      end
   end

   always_comb begin
      if (a_ff > etd_pkg::HALF_PI_Q60) begin
         f_in    = etd_pkg::PI_Q60 - a_ff;
         flip_in = 1'b1;
      end else if (a_ff < -etd_pkg::HALF_PI_Q60) begin
         f_in    = -etd_pkg::PI_Q60 - a_ff;
         flip_in = 1'b1;
      end else begin
         f_in    = a_ff;
         flip_in = 1'b0;
      end
      zr_in = (f_in + ZHALF) >>> ZSH;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= X_INIT;
         y_ff[0]    <= '0;
         z_ff[0]    <= zr_in[DATA_WIDTH-1:0];
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic signed [DATA_WIDTH-1:0] ATAN_I =
         (DATA_WIDTH)'(etd_pkg::rnd64(etd_pkg::atan_q62(i), 62 - FRAC));
      logic signed [DATA_WIDTH-1:0] dx;
      logic signed [DATA_WIDTH-1:0] dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][DATA_WIDTH-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - ATAN_I;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + ATAN_I;
            end
         end
      end
   end

   always_comb begin
      cx = 64'(x_ff[CORDIC_STAGES]);
      if (flip_ff[CORDIC_STAGES]) begin
         cx = -cx;
      end
      cy    = 64'(y_ff[CORDIC_STAGES]);
      cq_in = ((cx + QHALF) >>> SH_R) <<< SH_L;
      sq_in = ((cy + QHALF) >>> SH_R) <<< SH_L;
      if (cq_in > 64'(etd_pkg::ONE_Q30)) begin
         cq_in = 64'(etd_pkg::ONE_Q30);
      end else if (cq_in < -64'(etd_pkg::ONE_Q30)) begin
         cq_in = -64'(etd_pkg::ONE_Q30);
      end
      if (sq_in > 64'(etd_pkg::ONE_Q30)) begin
         sq_in = 64'(etd_pkg::ONE_Q30);
      end else if (sq_in < -64'(etd_pkg::ONE_Q30)) begin
         sq_in = -64'(etd_pkg::ONE_Q30);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cq_in[31:0];
         sin_ff <= sq_in[31:0];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// File: hdl/etd_matrix.sv
// Merging stage: products of the lane results and order-specific matrix assembly.
module etd_matrix (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] s1,
   input  logic signed [31:0] c1,
   input  logic signed [31:0] s2,
   input  logic signed [31:0] c2,
   input  logic signed [31:0] s3,
   input  logic signed [31:0] c3,
   input  logic [3:0]         order,
   output logic signed [31:0] m00,
   output logic signed [31:0] m01,
   output logic signed [31:0] m02,
   output logic signed [31:0] m10,
   output logic signed [31:0] m11,
   output logic signed [31:0] m12,
   output logic signed [31:0] m20,
   output logic signed [31:0] m21,
   output logic signed [31:0] m22
);

   function automatic logic signed [31:0] pr(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      p = (p + 64'sd536870912) >>> 30;
      return p[31:0];
   endfunction

   function automatic logic signed [33:0] sx(input logic signed [31:0] a);
      return 34'(a);
   endfunction

   logic signed [31:0] s2_ff, c2_ff, s3_ff, c3_ff;
   logic [3:0]         ord1_ff;
   logic signed [31:0] s1s2_ff, s1c2_ff, c1s2_ff, c1c2_ff;
   logic signed [31:0] s1s3_ff, s1c3_ff, c1s3_ff, c1c3_ff;
   logic signed [31:0] s2s3_ff, s2c3_ff, c2s3_ff, c2c3_ff;

   logic signed [31:0] s2b_ff, c2b_ff;
   logic [3:0]         ord2_ff;
   logic signed [31:0] s1s3b_ff, s1c3b_ff, c1s3b_ff, c1c3b_ff;
   logic signed [31:0] s2s3b_ff, s2c3b_ff, c2s3b_ff, c2c3b_ff;
   logic signed [31:0] s1s2b_ff, s1c2b_ff, c1s2b_ff, c1c2b_ff;
   logic signed [31:0] s1s2s3_ff, s1s2c3_ff, c1s2s3_ff, c1s2c3_ff;
   logic signed [31:0] s1c2s3_ff, s1c2c3_ff, c1c2s3_ff, c1c2c3_ff;

   logic signed [33:0] d_in [0:8];
   logic signed [31:0] m_ff [0:8];

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff   <= s2;
         c2_ff   <= c2;
         s3_ff   <= s3;
         c3_ff   <= c3;
         ord1_ff <= order;
         s1s2_ff <= pr(s1, s2);
         s1c2_ff <= pr(s1, c2);
         c1s2_ff <= pr(c1, s2);
         c1c2_ff <= pr(c1, c2);
         s1s3_ff <= pr(s1, s3);
         s1c3_ff <= pr(s1, c3);
         c1s3_ff <= pr(c1, s3);
         c1c3_ff <= pr(c1, c3);
         s2s3_ff <= pr(s2, s3);
         s2c3_ff <= pr(s2, c3);
         c2s3_ff <= pr(c2, s3);
         c2c3_ff <= pr(c2, c3);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2b_ff    <= s2_ff;
         c2b_ff    <= c2_ff;
         ord2_ff   <= ord1_ff;
         s1s3b_ff  <= s1s3_ff;
         s1c3b_ff  <= s1c3_ff;
         c1s3b_ff  <= c1s3_ff;
         c1c3b_ff  <= c1c3_ff;
         s2s3b_ff  <= s2s3_ff;
         s2c3b_ff  <= s2c3_ff;
         c2s3b_ff  <= c2s3_ff;
         c2c3b_ff  <= c2c3_ff;
         s1s2b_ff  <= s1s2_ff;
         s1c2b_ff  <= s1c2_ff;
         c1s2b_ff  <= c1s2_ff;
         c1c2b_ff  <= c1c2_ff;
         s1s2s3_ff <= pr(s1s2_ff, s3_ff);
         s1s2c3_ff <= pr(s1s2_ff, c3_ff);
         c1s2s3_ff <= pr(c1s2_ff, s3_ff);
         c1s2c3_ff <= pr(c1s2_ff, c3_ff);
         s1c2s3_ff <= pr(s1c2_ff, s3_ff);
         s1c2c3_ff <= pr(s1c2_ff, c3_ff);
         c1c2s3_ff <= pr(c1c2_ff, s3_ff);
         c1c2c3_ff <= pr(c1c2_ff, c3_ff);
      end
   end

   always_comb begin
      case (ord2_ff)
         etd_pkg::ORD_XYZ: begin
            d_in[0] = sx(c2c3b_ff);
            d_in[1] = sx(s1s2c3_ff) + sx(c1s3b_ff);
            d_in[2] = sx(s1s3b_ff) - sx(c1s2c3_ff);
            d_in[3] = -sx(c2s3b_ff);
            d_in[4] = sx(c1c3b_ff) - sx(s1s2s3_ff);
            d_in[5] = sx(c1s2s3_ff) + sx(s1c3b_ff);
            d_in[6] = sx(s2b_ff);
            d_in[7] = -sx(s1c2b_ff);
            d_in[8] = sx(c1c2b_ff);
         end
         etd_pkg::ORD_XYX: begin
            d_in[0] = sx(c2b_ff);
            d_in[1] = sx(s1s2b_ff);
            d_in[2] = -sx(c1s2b_ff);
            d_in[3] = sx(s2s3b_ff);
            d_in[4] = sx(c1c3b_ff) - sx(s1c2s3_ff);
            d_in[5] = sx(c1c2s3_ff) + sx(s1c3b_ff);
            d_in[6] = sx(s2c3b_ff);
            d_in[7] = -sx(s1c2c3_ff) - sx(c1s3b_ff);
            d_in[8] = sx(c1c2c3_ff) - sx(s1s3b_ff);
         end
         etd_pkg::ORD_XZY: begin
            d_in[0] = sx(c2c3b_ff);
            d_in[1] = sx(c1s2c3_ff) + sx(s1s3b_ff);
            d_in[2] = sx(s1s2c3_ff) - sx(c1s3b_ff);
            d_in[3] = -sx(s2b_ff);
            d_in[4] = sx(c1c2b_ff);
            d_in[5] = sx(s1c2b_ff);
            d_in[6] = sx(c2s3b_ff);
            d_in[7] = sx(c1s2s3_ff) - sx(s1c3b_ff);
            d_in[8] = sx(s1s2s3_ff) + sx(c1c3b_ff);
         end
         etd_pkg::ORD_XZX: begin
            d_in[0] = sx(c2b_ff);
            d_in[1] = sx(c1s2b_ff);
            d_in[2] = sx(s1s2b_ff);
            d_in[3] = -sx(s2c3b_ff);
            d_in[4] = sx(c1c2c3_ff) - sx(s1s3b_ff);
            d_in[5] = sx(s1c2c3_ff) + sx(c1s3b_ff);
            d_in[6] = sx(s2s3b_ff);
            d_in[7] = -sx(c1c2s3_ff) - sx(s1c3b_ff);
            d_in[8] = sx(c1c3b_ff) - sx(s1c2s3_ff);
         end
         etd_pkg::ORD_YXZ: begin
            d_in[0] = sx(c1c3b_ff) + sx(s1s2s3_ff);
            d_in[1] = sx(c2s3b_ff);
            d_in[2] = sx(c1s2s3_ff) - sx(s1c3b_ff);
            d_in[3] = sx(s1s2c3_ff) - sx(c1s3b_ff);
            d_in[4] = sx(c2c3b_ff);
            d_in[5] = sx(c1s2c3_ff) + sx(s1s3b_ff);
            d_in[6] = sx(s1c2b_ff);
            d_in[7] = -sx(s2b_ff);
            d_in[8] = sx(c1c2b_ff);
         end
         etd_pkg::ORD_YXY: begin
            d_in[0] = sx(c1c3b_ff) - sx(s1c2s3_ff);
            d_in[1] = sx(s2s3b_ff);
            d_in[2] = -sx(c1c2s3_ff) - sx(s1c3b_ff);
            d_in[3] = sx(s1s2b_ff);
            d_in[4] = sx(c2b_ff);
            d_in[5] = sx(c1s2b_ff);
            d_in[6] = sx(s1c2c3_ff) + sx(c1s3b_ff);
            d_in[7] = -sx(s2c3b_ff);
            d_in[8] = sx(c1c2c3_ff) - sx(s1s3b_ff);
         end
         etd_pkg::ORD_YZX: begin
            d_in[0] = sx(c1c2b_ff);
            d_in[1] = sx(s2b_ff);
            d_in[2] = -sx(s1c2b_ff);
            d_in[3] = sx(s1s3b_ff) - sx(c1s2c3_ff);
            d_in[4] = sx(c2c3b_ff);
            d_in[5] = sx(c1s3b_ff) + sx(s1s2c3_ff);
            d_in[6] = sx(c1s2s3_ff) + sx(s1c3b_ff);
            d_in[7] = -sx(c2s3b_ff);
            d_in[8] = sx(c1c3b_ff) - sx(s1s2s3_ff);
         end
         etd_pkg::ORD_YZY: begin
            d_in[0] = sx(c1c2c3_ff) - sx(s1s3b_ff);
            d_in[1] = sx(s2c3b_ff);
            d_in[2] = -sx(s1c2c3_ff) - sx(c1s3b_ff);
            d_in[3] = -sx(c1s2b_ff);
            d_in[4] = sx(c2b_ff);
            d_in[5] = sx(s1s2b_ff);
            d_in[6] = sx(c1c2s3_ff) + sx(s1c3b_ff);
            d_in[7] = sx(s2s3b_ff);
            d_in[8] = -sx(s1c2s3_ff) + sx(c1c3b_ff);
         end
         etd_pkg::ORD_ZYZ: begin
            d_in[0] = sx(c1c2c3_ff) - sx(s1s3b_ff);
            d_in[1] = sx(s1c2c3_ff) + sx(c1s3b_ff);
            d_in[2] = -sx(s2c3b_ff);
            d_in[3] = -sx(c1c2s3_ff) - sx(s1c3b_ff);
            d_in[4] = sx(c1c3b_ff) - sx(s1c2s3_ff);
            d_in[5] = sx(s2s3b_ff);
            d_in[6] = sx(c1s2b_ff);
            d_in[7] = sx(s1s2b_ff);
            d_in[8] = sx(c2b_ff);
         end
         etd_pkg::ORD_ZXY: begin
            d_in[0] = sx(c1c3b_ff) - sx(s1s2s3_ff);
            d_in[1] = sx(s1c3b_ff) + sx(c1s2s3_ff);
            d_in[2] = -sx(c2s3b_ff);
            d_in[3] = -sx(s1c2b_ff);
            d_in[4] = sx(c1c2b_ff);
            d_in[5] = sx(s2b_ff);
            d_in[6] = sx(c1s3b_ff) + sx(s1s2c3_ff);
            d_in[7] = sx(s1s3b_ff) - sx(c1s2c3_ff);
            d_in[8] = sx(c2c3b_ff);
         end
         etd_pkg::ORD_ZXZ: begin
            d_in[0] = sx(c1c3b_ff) - sx(s1c2s3_ff);
            d_in[1] = sx(c1c2s3_ff) + sx(s1c3b_ff);
            d_in[2] = sx(s2s3b_ff);
            d_in[3] = -sx(s1c2c3_ff) - sx(c1s3b_ff);
            d_in[4] = sx(c1c2c3_ff) - sx(s1s3b_ff);
            d_in[5] = sx(s2c3b_ff);
            d_in[6] = sx(s1s2b_ff);
            d_in[7] = -sx(c1s2b_ff);
            d_in[8] = sx(c2b_ff);
         end
         default: begin
            d_in[0] = sx(c1c2b_ff);
            d_in[1] = sx(s1c2b_ff);
            d_in[2] = -sx(s2b_ff);
            d_in[3] = sx(c1s2s3_ff) - sx(s1c3b_ff);
            d_in[4] = sx(s1s2s3_ff) + sx(c1c3b_ff);
            d_in[5] = sx(c2s3b_ff);
            d_in[6] = sx(c1s2c3_ff) + sx(s1s3b_ff);
            d_in[7] = sx(s1s2c3_ff) - sx(c1s3b_ff);
            d_in[8] = sx(c2c3b_ff);
         end
      endcase
   end

   for (genvar j = 0; j < 9; j++) begin : g_elem
      always_ff @(posedge clock) begin
         if (en) begin
            if (d_in[j] > sx(etd_pkg::ONE_Q30)) begin
               m_ff[j] <= etd_pkg::ONE_Q30;
            end else if (d_in[j] < -sx(etd_pkg::ONE_Q30)) begin
               m_ff[j] <= -etd_pkg::ONE_Q30;
            end else begin
               m_ff[j] <= d_in[j][31:0];
            end
         end
      end
   end

   assign m00 = m_ff[0];
   assign m01 = m_ff[1];
   assign m02 = m_ff[2];
   assign m10 = m_ff[3];
   assign m11 = m_ff[4];
   assign m12 = m_ff[5];
   assign m20 = m_ff[6];
   assign m21 = m_ff[7];
   assign m22 = m_ff[8];

endmodule

// File: hdl/euler_angles_to_dcm.sv
// Top level of the Euler angle to direction cosine matrix converter.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid/req_ready    three Q4.28 angles, order code
//   rsp_     out        rsp_valid/rsp_ready    nine Q2.30 matrix elements
//
// One request enters per cycle unless the pipeline holds. Each request passes
// the CORDIC pipeline in each of the three angle lanes, then the product stages.
// Reset clears only the valid bits of the pipeline.
// When a result waits and rsp_ready is low, the whole pipeline holds and
// req_ready falls; otherwise requests flow every cycle.
`include "assert_macros.svh"

module euler_angles_to_dcm #(
   parameter int DATA_WIDTH    = 32,
   parameter int CORDIC_STAGES = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_angle_first,
   input  logic signed [31:0] req_angle_second,
   input  logic signed [31:0] req_angle_third,
   input  logic [3:0]         req_order_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_m00,
   output logic signed [31:0] rsp_m01,
   output logic signed [31:0] rsp_m02,
   output logic signed [31:0] rsp_m10,
   output logic signed [31:0] rsp_m11,
   output logic signed [31:0] rsp_m12,
   output logic signed [31:0] rsp_m20,
   output logic signed [31:0] rsp_m21,
   output logic signed [31:0] rsp_m22
);

   localparam int LANE_LAT = CORDIC_STAGES + 3;
   localparam int TOTAL    = LANE_LAT + 3;

   logic               en;
   logic [TOTAL-1:0]   valid_ff;
   logic [TOTAL-1:0]   valid_in;
   logic [3:0]         ord_ff [0:LANE_LAT-1];
   logic signed [31:0] s1, c1, s2, c2, s3, c3;
   logic               rsp_in_range;

   assign en        = !valid_ff[TOTAL-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[TOTAL-1];

   assign valid_in = {valid_ff[TOTAL-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ord_ff[0] <= req_order_code;
         for (int k = 1; k < LANE_LAT; k++) begin
            ord_ff[k] <= ord_ff[k-1];
         end
      end
   end

   etd_sincos #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_lane1 (
      .clock(clock), .en(en), .angle(req_angle_first), .sin_out(s1), .cos_out(c1)
   );
   etd_sincos #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_lane2 (
      .clock(clock), .en(en), .angle(req_angle_second), .sin_out(s2), .cos_out(c2)
   );
   etd_sincos #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_lane3 (
      .clock(clock), .en(en), .angle(req_angle_third), .sin_out(s3), .cos_out(c3)
   );

   etd_matrix u_matrix (
      .clock(clock), .en(en),
      .s1(s1), .c1(c1), .s2(s2), .c2(c2), .s3(s3), .c3(c3),
      .order(ord_ff[LANE_LAT-1]),
      .m00(rsp_m00), .m01(rsp_m01), .m02(rsp_m02),
      .m10(rsp_m10), .m11(rsp_m11), .m12(rsp_m12),
      .m20(rsp_m20), .m21(rsp_m21), .m22(rsp_m22)
   );

   assign rsp_in_range =
      (rsp_m00 <= etd_pkg::ONE_Q30) && (rsp_m00 >= -etd_pkg::ONE_Q30) &&
      (rsp_m01 <= etd_pkg::ONE_Q30) && (rsp_m01 >= -etd_pkg::ONE_Q30) &&
      (rsp_m02 <= etd_pkg::ONE_Q30) && (rsp_m02 >= -etd_pkg::ONE_Q30) &&
      (rsp_m10 <= etd_pkg::ONE_Q30) && (rsp_m10 >= -etd_pkg::ONE_Q30) &&
      (rsp_m11 <= etd_pkg::ONE_Q30) && (rsp_m11 >= -etd_pkg::ONE_Q30) &&
      (rsp_m12 <= etd_pkg::ONE_Q30) && (rsp_m12 >= -etd_pkg::ONE_Q30) &&
      (rsp_m20 <= etd_pkg::ONE_Q30) && (rsp_m20 >= -etd_pkg::ONE_Q30) &&
      (rsp_m21 <= etd_pkg::ONE_Q30) && (rsp_m21 >= -etd_pkg::ONE_Q30) &&
      (rsp_m22 <= etd_pkg::ONE_Q30) && (rsp_m22 >= -etd_pkg::ONE_Q30);

   `ETD_ASSERT_NOW(a_rsp_clamped, clock, reset, rsp_valid, rsp_in_range, "element out of range")
   `ETD_ASSERT_NOW(a_stall_only_full, clock, reset, !req_ready, rsp_valid, "stall without result")
   `ETD_ASSERT_NEXT(a_req_enters, clock, reset, req_valid && req_ready, valid_ff[0], "request lost")
   `ETD_ASSERT_NEXT(a_rsp_drains, clock, reset, rsp_valid && rsp_ready && !valid_ff[TOTAL-2],
                    !rsp_valid, "result repeated")

endmodule

// File: bench/euler_angles_to_dcm_tb.sv
// Self-checking testbench for the Euler angle to direction cosine matrix converter.
module euler_angles_to_dcm_tb;
   import etd_pkg::*;

   localparam int  LATENCY   = 36;
   localparam int  NUM_RAND  = 1000;
   localparam int  QUIET_AT  = 850;
   localparam longint ONE30  = longint'(1) << 30;
   localparam int  PI_Q28    = 843314857;

   typedef struct {
      longint m[9];
   } dcm_type;

   class dcm_scoreboard;
      dcm_type pending[$];
      int     errors;
      longint atan_tab[64];
      string  names[9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

      function new();
         errors = 0;
         for (int i = 0; i < 64; i++) begin
            atan_tab[i] = 0;
            if (i == 0) begin
               atan_tab[i] = QUARTER_PI_Q62;
            end else begin
               for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                  if (k % 2 == 1) begin
                     atan_tab[i] -= longint'((64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1));
                  end else begin
                     atan_tab[i] += longint'((64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1));
                  end
               end
            end
         end
      endfunction

      function longint rnd(longint v, int s);
         if (s == 0) return v;
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function longint clamp(longint v);
         if (v > ONE30) return ONE30;
         if (v < -ONE30) return -ONE30;
         return v;
      endfunction

      function longint p2(longint a, longint b);
         return rnd(a * b, 30);
      endfunction

      function longint p3(longint a, longint b, longint c);
         return rnd(p2(a, b) * c, 30);
      endfunction

      function void sin_cos(logic signed [31:0] ang, output longint s, output longint c);
         longint a, x, y, z, dx, dy;
         bit flip;
         a = longint'(ang) <<< 32;
         flip = 0;
         while (a > PI_Q60) a -= TWO_PI_Q60;
         while (a < -PI_Q60) a += TWO_PI_Q60;
         if (a > HALF_PI_Q60) begin
            a = PI_Q60 - a;
            flip = 1;
         end else if (a < -HALF_PI_Q60) begin
            a = -PI_Q60 - a;
            flip = 1;
         end
         z = rnd(a, 30);
         x = rnd(GAIN_Q62, 32);
         y = 0;
         for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= rnd(atan_tab[i], 32);
            end else begin
               x += dx; y -= dy; z += rnd(atan_tab[i], 32);
            end
         end
         c = clamp(flip ? -x : x);
         s = clamp(y);
      endfunction

      function void note_request(logic signed [31:0] a1, logic signed [31:0] a2,
                                 logic signed [31:0] a3, logic [3:0] code);
         longint s1, c1, s2, c2, s3, c3;
         longint d[9];
         dcm_type e;
         sin_cos(a1, s1, c1);
         sin_cos(a2, s2, c2);
         sin_cos(a3, s3, c3);
         case (order_type'(code))
            ORD_XYZ: d = '{p2(c2, c3), p3(s1, s2, c3) + p2(c1, s3), p2(s1, s3) - p3(c1, s2, c3),
                           -p2(c2, s3), p2(c1, c3) - p3(s1, s2, s3), p3(c1, s2, s3) + p2(s1, c3),
                           s2, -p2(s1, c2), p2(c1, c2)};
            ORD_XYX: d = '{c2, p2(s1, s2), -p2(c1, s2),
                           p2(s2, s3), p2(c1, c3) - p3(s1, c2, s3), p3(c1, c2, s3) + p2(s1, c3),
                           p2(s2, c3), -p3(s1, c2, c3) - p2(c1, s3), p3(c1, c2, c3) - p2(s1, s3)};
            ORD_XZY: d = '{p2(c2, c3), p3(c1, s2, c3) + p2(s1, s3), p3(s1, s2, c3) - p2(c1, s3),
                           -s2, p2(c1, c2), p2(s1, c2),
                           p2(c2, s3), p3(c1, s2, s3) - p2(s1, c3), p3(s1, s2, s3) + p2(c1, c3)};
            ORD_XZX: d = '{c2, p2(c1, s2), p2(s1, s2),
                           -p2(s2, c3), p3(c1, c2, c3) - p2(s1, s3), p3(s1, c2, c3) + p2(c1, s3),
                           p2(s2, s3), -p3(c1, c2, s3) - p2(s1, c3), p2(c1, c3) - p3(s1, c2, s3)};
            ORD_YXZ: d = '{p2(c1, c3) + p3(s1, s2, s3), p2(c2, s3), p3(c1, s2, s3) - p2(s1, c3),
                           p3(s1, s2, c3) - p2(c1, s3), p2(c2, c3), p3(c1, s2, c3) + p2(s1, s3),
                           p2(s1, c2), -s2, p2(c1, c2)};
            ORD_YXY: d = '{p2(c1, c3) - p3(s1, c2, s3), p2(s2, s3), -p3(c1, c2, s3) - p2(s1, c3),
                           p2(s1, s2), c2, p2(c1, s2),
                           p3(s1, c2, c3) + p2(c1, s3), -p2(s2, c3), p3(c1, c2, c3) - p2(s1, s3)};
            ORD_YZX: d = '{p2(c1, c2), s2, -p2(s1, c2),
                           p2(s1, s3) - p3(c1, s2, c3), p2(c2, c3), p2(c1, s3) + p3(s1, s2, c3),
                           p3(c1, s2, s3) + p2(s1, c3), -p2(c2, s3), p2(c1, c3) - p3(s1, s2, s3)};
            ORD_YZY: d = '{p3(c1, c2, c3) - p2(s1, s3), p2(s2, c3), -p3(s1, c2, c3) - p2(c1, s3),
                           -p2(c1, s2), c2, p2(s1, s2),
                           p3(c1, c2, s3) + p2(s1, c3), p2(s2, s3), -p3(s1, c2, s3) + p2(c1, c3)};
            ORD_ZYZ: d = '{p3(c1, c2, c3) - p2(s1, s3), p3(s1, c2, c3) + p2(c1, s3), -p2(s2, c3),
                           -p3(c1, c2, s3) - p2(s1, c3), p2(c1, c3) - p3(s1, c2, s3), p2(s2, s3),
                           p2(c1, s2), p2(s1, s2), c2};
            ORD_ZXY: d = '{p2(c1, c3) - p3(s1, s2, s3), p2(s1, c3) + p3(c1, s2, s3), -p2(c2, s3),
                           -p2(s1, c2), p2(c1, c2), s2,
                           p2(c1, s3) + p3(s1, s2, c3), p2(s1, s3) - p3(c1, s2, c3), p2(c2, c3)};
            ORD_ZXZ: d = '{p2(c1, c3) - p3(s1, c2, s3), p3(c1, c2, s3) + p2(s1, c3), p2(s2, s3),
                           -p3(s1, c2, c3) - p2(c1, s3), p3(c1, c2, c3) - p2(s1, s3), p2(s2, c3),
                           p2(s1, s2), -p2(c1, s2), c2};
            default: d = '{p2(c1, c2), p2(s1, c2), -s2,
                           p3(c1, s2, s3) - p2(s1, c3), p3(s1, s2, s3) + p2(c1, c3), p2(c2, s3),
                           p3(c1, s2, c3) + p2(s1, s3), p3(s1, s2, c3) - p2(c1, s3), p2(c2, c3)};
         endcase
         for (int j = 0; j < 9; j++) e.m[j] = clamp(d[j]);
         pending.push_back(e);
      endfunction

      function void check_result(longint act[9]);
         dcm_type e;
         if (pending.size() == 0) begin
            $error("matrix result arrived with no request outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         for (int j = 0; j < 9; j++) begin
            if (act[j] != e.m[j]) begin
               $error("%s expected %0d actual %0d", names[j], e.m[j], act[j]);
               errors++;
            end
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [31:0] req_angle_first = '0;
   logic signed [31:0] req_angle_second = '0;
   logic signed [31:0] req_angle_third = '0;
   logic [3:0]         req_order_code = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [31:0] rsp_m20, rsp_m21, rsp_m22;

   dcm_scoreboard sb = new();
   bit quiet = 0;
   bit hold_req = 0;

   euler_angles_to_dcm u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_request(req_angle_first, req_angle_second, req_angle_third, req_order_code);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result('{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                           rsp_m20, rsp_m21, rsp_m22});
      end
   end

   task automatic send_request(logic signed [31:0] a1, logic signed [31:0] a2,
                               logic signed [31:0] a3, logic [3:0] code);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_angle_first  <= a1;
      req_angle_second <= a2;
      req_angle_third  <= a3;
      req_order_code   <= code;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [31:0] pick_angle();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 2 * PI_Q28) - PI_Q28;
         2: return $urandom_range(0, 2 * PI_Q28) - PI_Q28;
         3: return $urandom_range(0, 8) * (PI_Q28 / 2) - 2 * PI_Q28 + $urandom_range(0, 4) - 2;
         default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      endcase
   endfunction

   logic signed [31:0] edge_angles[8] = '{0, 32'sh7FFFFFFF, 32'sh80000000, PI_Q28, -PI_Q28,
                                          PI_Q28 / 2, -(PI_Q28 / 2), 1};

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      rsp_ready <= 1'b1;
      for (int code = 0; code < 16; code++) begin
         send_request(edge_angles[code % 8], edge_angles[(code + 3) % 8],
                      edge_angles[(code + 5) % 8], 4'(code));
      end
      for (int n = 0; n < 8; n++) begin
         send_request(edge_angles[n], edge_angles[7 - n], edge_angles[(n + 1) % 8], 4'(n + 8));
      end
      for (int n = 0; n < NUM_RAND; n++) begin
         if (n == 300) hold_req = 1;
         if (n == 600) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending.size() != 0) @(posedge clock);
         end
         if (n == QUIET_AT) quiet = 1;
         send_request(pick_angle(), pick_angle(), pick_angle(), 4'($urandom_range(0, 15)));
      end
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_ready <= 1'b0;
            repeat (120) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
